### sv/pli_pkg.sv
// ----------------------------------------------------------------------------
// Positional list package
// Shared constants, operation and status codes, and the command and status
// structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
package pli_pkg;

    // Number of entries the list can hold.
    localparam int CAPACITY = 16;

    // Field widths of the transactions.
    localparam int VAL_W = 32;
    localparam int POS_W = 5;
    localparam int CNT_W = 5;
    localparam int OP_W  = 2;

    // Width of an index into the entry cells.
    localparam int IDX_W = $clog2(CAPACITY);

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_DELETE = 2'd1;
    localparam op_t OP_DUMP   = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic             load_out;
        logic             do_insert;
        logic             do_delete;
        logic             from_cell;
        logic [IDX_W-1:0] rd_idx;
        status_t          status;
        logic             last;
    } pli_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             out_free;
    } pli_stat_t;

endpackage

### sv/pli_if.sv
// ----------------------------------------------------------------------------
// Positional list channel interfaces
// Request channel (operation, position, value) and result channel (value,
// status, count, last marker), each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pli_req_if;
    logic                      valid;
    logic                      ready;
    logic [pli_pkg::OP_W-1:0]  operation;
    logic [pli_pkg::POS_W-1:0] position;
    logic signed [pli_pkg::VAL_W-1:0] new_value;

    modport source (output valid, output operation, output position, output new_value,
                    input ready);
    modport sink   (input valid, input operation, input position, input new_value,
                    output ready);
endinterface

interface pli_rsp_if;
    logic                      valid;
    logic                      ready;
    logic signed [pli_pkg::VAL_W-1:0] item_value;
    logic [1:0]                status;
    logic [pli_pkg::CNT_W-1:0] list_count;
    logic                      last;

    modport source (output valid, output item_value, output status, output list_count,
                    output last, input ready);
    modport sink   (input valid, input item_value, input status, input list_count,
                    input last, output ready);
endinterface

### sv/pli_ctrl.sv
// ----------------------------------------------------------------------------
// Positional list controller
// Decodes each request transaction, checks it against the entry count and
// sequences the entry stream of a dump.
// ----------------------------------------------------------------------------
module pli_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  pli_pkg::op_t              operation,
    input  logic [pli_pkg::POS_W-1:0] position,
    input  pli_pkg::pli_stat_t        dp_stat,
    output pli_pkg::pli_cmd_t         cmd
);
    import pli_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             accept;
    logic             dump_last;

    assign req_ready = (state_reg == S_IDLE) && dp_stat.out_free;
    assign accept    = req_valid && req_ready;
    assign dump_last = (CNT_W'(idx_reg) + CNT_W'(1)) == dp_stat.count;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd.load_out  = 1'b0;
        cmd.do_insert = 1'b0;
        cmd.do_delete = 1'b0;
        cmd.from_cell = 1'b0;
        cmd.rd_idx    = idx_reg;
        cmd.status    = ST_DONE;
        cmd.last      = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_out = 1'b1;
                    case (operation)
                        OP_INSERT:
                        begin
                            if (CNT_W'(position) > dp_stat.count)
                                cmd.status = ST_RANGE;
                            else if (dp_stat.count >= CNT_W'(CAPACITY))
                                cmd.status = ST_FULL;
                            else
                                cmd.do_insert = 1'b1;
                        end
                        OP_DELETE:
                        begin
                            if (dp_stat.count == '0)
                                cmd.status = ST_EMPTY;
                            else if (CNT_W'(position) >= dp_stat.count)
                                cmd.status = ST_RANGE;
                            else
                                cmd.do_delete = 1'b1;
                        end
                        OP_DUMP:
                        begin
                            if (dp_stat.count == '0)
                            begin
                                cmd.status = ST_EMPTY;
                            end
                            else
                            begin
                                // Dump state sends one entry per cycle unless stalled.
                                cmd.load_out = 1'b0;
                                idx_next     = '0;
                                state_next   = S_DUMP;
                            end
                        end
                        default:
                        begin
                            cmd.status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (dp_stat.out_free)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.from_cell = 1'b1;
                    cmd.last      = dump_last;
                    if (dump_last)
                        state_next = S_IDLE;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

### sv/pli_dp.sv
// ----------------------------------------------------------------------------
// Positional list datapath
// Holds the entry cells and entry count, shifts the cells from the position
// onward in parallel on an insert or delete, registers the result transaction.
// ----------------------------------------------------------------------------
module pli_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [pli_pkg::POS_W-1:0]        position,
    input  logic signed [pli_pkg::VAL_W-1:0] new_value,
    input  pli_pkg::pli_cmd_t                cmd,
    output pli_pkg::pli_stat_t               dp_stat,
    pli_rsp_if.source                        rsp
);
    import pli_pkg::*;

    logic [VAL_W-1:0] cells_reg  [CAPACITY];
    logic [VAL_W-1:0] cells_next [CAPACITY];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic [VAL_W-1:0] out_value_reg;
    status_t          out_status_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             out_last_reg;

    always_comb
    begin
        cells_next = cells_reg;
        if (cmd.do_insert)
        begin
            for (int i = 1; i < CAPACITY; i++)
            begin
                if (POS_W'(i) > position)
                    cells_next[i] = cells_reg[i-1];
            end
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (POS_W'(i) == position)
                    cells_next[i] = new_value;
            end
        end
        else if (cmd.do_delete)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                if (POS_W'(i) >= position)
                    cells_next[i] = cells_reg[i+1];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_insert)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.do_delete)
            count_next = count_reg - CNT_W'(1);
    end

    assign dp_stat.count    = count_reg;
    assign dp_stat.out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk)
    begin
        cells_reg <= cells_next;
        if (cmd.load_out)
        begin
            out_value_reg  <= cmd.from_cell ? cells_reg[cmd.rd_idx] : '0;
            out_status_reg <= cmd.status;
            out_count_reg  <= count_next;
            out_last_reg   <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.item_value = out_value_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.list_count = out_count_reg;
    assign rsp.last       = out_last_reg;

endmodule

### sv/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Positional list with insert and delete at an index
// Ordered list of up to CAPACITY signed 32-bit values with insert, delete and
// dump operations, each answered by result transactions on a separate channel.
// ----------------------------------------------------------------------------
// On an insert or delete request, the entry cells shift in parallel in the
// cycle the request transaction is accepted, and the single result (status
// and new count, last set) sits in the output register from the next cycle.
// A new request is taken in the same cycle that the previous result is taken,
// so inserts and deletes run at one per cycle while the result side keeps up.
// A dump of N entries streams N results, one per cycle while the result side
// keeps up, read from the entry cells by the controller's index counter; no
// request is taken while it runs. A dump of an empty list, an unknown
// operation and every rejected request give one result. Status codes: done,
// position out of range (a position greater than the count for insert, equal to
// or greater than the count for delete), list full, list empty. Entry cells
// have no reset; only entries below the count are ever shown.
// ----------------------------------------------------------------------------
module positional_list_insert_delete (
    input  logic      clk,
    input  logic      rst_n,
    pli_req_if.sink   req,
    pli_rsp_if.source rsp
);
    import pli_pkg::*;

    pli_cmd_t  cmd;
    pli_stat_t dp_stat;

    // Controller: request decode, range checks, dump sequencing.
    pli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .operation (req.operation),
        .position  (req.position),
        .dp_stat   (dp_stat),
        .cmd       (cmd)
    );

    // Datapath: entry cells, entry count and result register.
    pli_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .position  (req.position),
        .new_value (req.new_value),
        .cmd       (cmd),
        .dp_stat   (dp_stat),
        .rsp       (rsp)
    );

endmodule

### sv/pli_checker.sv
// ----------------------------------------------------------------------------
// Positional list checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pli_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [pli_pkg::VAL_W-1:0] item_value,
    input logic [1:0]                status,
    input logic [pli_pkg::CNT_W-1:0] list_count,
    input logic                      last
);
    import pli_pkg::*;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> list_count <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    // Only a successful dump produces results that are not the last.
    a_mid_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> status == ST_DONE)
        else $error("non-final result with error status");

    // A full rejection reports a full list, an empty one an empty list.
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FULL || status == ST_EMPTY) |->
        (status == ST_FULL ? list_count == CNT_W'(CAPACITY) : list_count == '0))
        else $error("full or empty status disagrees with count");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(item_value) && $stable(status)
        && $stable(list_count) && $stable(last))
        else $error("stalled result changed");

endmodule

bind positional_list_insert_delete pli_checker u_pli_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .item_value (rsp.item_value),
    .status     (rsp.status),
    .list_count (rsp.list_count),
    .last       (rsp.last)
);
